>>> design/bte_pkg.sv
// bezier trajectory evaluator package: op codes, widths, sizes, shared types
// no dependencies

package bte_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned ValueW = 48;
    localparam int unsigned WorkW  = 64;

    // trajectory size, fixed by the item field widths
    localparam int unsigned MaxSegments = 8;
    localparam int unsigned CurveOrder  = 7;

    typedef enum logic [1:0] {
        OP_LOAD_POINT = 2'd0,
        OP_LOAD_DUR   = 2'd1,
        OP_EVALUATE   = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [2:0]  segment_index;
        logic [31:0] segment_duration;
        logic [31:0] query_time;
        logic [2:0]  deriv_order;
    } t_in_item;

    typedef struct packed {
        logic [47:0] value_x;
        logic [47:0] value_y;
        logic [2:0]  segment_found;
        logic        beyond_end;
    } t_out_item;

    // divider control between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } t_div_rsp;

endpackage

>>> design/bte_if.sv
// valid/ready channel interfaces for the evaluator
// depends on bte_pkg

interface bte_in_if;
    logic                valid;
    logic                ready;
    bte_pkg::t_in_item   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bte_out_if;
    logic                valid;
    logic                ready;
    bte_pkg::t_out_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bte_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/bte_ram.sv
// generic ram with separate read and write ports and registered read
// no dependencies

module bte_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 57
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/bte_div.sv
// restoring divider, one quotient bit per cycle, 17-bit quotient
// depends on bte_pkg

module bte_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bte_pkg::t_div_req i_req,
    output bte_pkg::t_div_rsp o_rsp
);
    logic [47:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [16:0] r_quo, n_quo;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [48:0] w_trial;

    // quotient below 2^17 as local time is below duration
    always_comb begin
        w_trial = {1'b0, r_rem} - ({17'd0, r_den} << r_cnt);
        n_rem = r_rem;
        n_quo = r_quo;
        if (!w_trial[48]) begin
            n_rem = w_trial[47:0];
            n_quo[r_cnt] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_quo  <= '0;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

>>> design/bezier_trajectory_evaluator_core.sv
// bezier trajectory evaluator core: sequencer, shared multiply-add datapath
// depends on bte_pkg, bte_if, bte_ram, bte_div
//
// loads are accepted in the idle state and can follow back to back
// an evaluate walks the segments (a duration read and a compare per segment), divides once the
// segment is found, then per axis does an 8-point load, the difference passes and the de casteljau
// passes on the one mac and a scale, and at last registers the result
// ready is low from acceptance until the result is registered; a stalled result holds it low
// synchronous active-low reset clears the sequencer and output valid, sets segment_count to 1

module bezier_trajectory_evaluator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bte_in_if.sink    in_ch,
    bte_out_if.source out_ch,
    bte_cfg_if.sink   cfg_ch
);
    localparam int unsigned MaxSegments = bte_pkg::MaxSegments;
    localparam int unsigned CurveOrder  = bte_pkg::CurveOrder;
    localparam int unsigned NumPoints = MaxSegments * CurveOrder + 1;
    localparam int unsigned PtAw      = $clog2(NumPoints);
    localparam int unsigned SegAw     = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
    localparam int unsigned NumW      = CurveOrder + 1;
    localparam int unsigned OrdW      = $clog2(CurveOrder + 1) + 1;
    localparam int unsigned WorkW_l   = bte_pkg::WorkW;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_WALK   = 10'b0000000010,
        ST_WDATA  = 10'b0000000100,
        ST_DIV    = 10'b0000001000,
        ST_LOAD   = 10'b0000010000,
        ST_DIFF   = 10'b0000100000,
        ST_INTERP = 10'b0001000000,
        ST_SCALE  = 10'b0010000000,
        ST_AXIS   = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } t_state;

    t_state r_state;

    // ---------------- configuration ----------------
    logic [3:0] r_seg_count;
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= 4'd1;
        end else if (cfg_ch.valid) begin
            r_seg_count <= cfg_ch.data;
        end
    end

    // ---------------- stores ----------------
    bte_pkg::t_in_item w_in;
    logic w_acc;
    assign w_in  = in_ch.payload;
    assign in_ch.ready = (r_state == ST_IDLE);
    assign w_acc = in_ch.valid && in_ch.ready;

    logic            w_pt_we, w_dur_we;
    logic [PtAw-1:0] r_pt_raddr;
    logic [SegAw-1:0] r_seg_raddr;
    logic [31:0]     w_px, w_py, w_dur;

    // ignore out-of-range writes
    assign w_pt_we  = w_acc && (w_in.op == bte_pkg::OP_LOAD_POINT)
                      && ({26'd0, w_in.point_index} < NumPoints);
    assign w_dur_we = w_acc && (w_in.op == bte_pkg::OP_LOAD_DUR)
                      && ({29'd0, w_in.segment_index} < MaxSegments);

    bte_ram #(.WIDTH(32), .DEPTH(NumPoints)) u_ram_x (
        .i_clk(i_clk), .i_we(w_pt_we), .i_waddr(w_in.point_index[PtAw-1:0]),
        .i_wdata(w_in.point_x), .i_raddr(r_pt_raddr), .o_rdata(w_px));
    bte_ram #(.WIDTH(32), .DEPTH(NumPoints)) u_ram_y (
        .i_clk(i_clk), .i_we(w_pt_we), .i_waddr(w_in.point_index[PtAw-1:0]),
        .i_wdata(w_in.point_y), .i_raddr(r_pt_raddr), .o_rdata(w_py));
    bte_ram #(.WIDTH(32), .DEPTH(MaxSegments)) u_ram_dur (
        .i_clk(i_clk), .i_we(w_dur_we), .i_waddr(w_in.segment_index[SegAw-1:0]),
        .i_wdata(w_in.segment_duration), .i_raddr(r_seg_raddr), .o_rdata(w_dur));

    // ---------------- evaluate context ----------------
    logic [31:0]  r_query;
    logic [2:0]   r_ord;
    logic [32:0]  r_acc_t;       // accumulated end time
    logic [6:0]   r_seg;         // current segment in walk
    logic [6:0]   r_cnt_lim;     // segments in use
    logic         r_found;
    logic [16:0]  r_u;
    logic [31:0]  r_seg_dur;
    logic         r_axis;        // 0 x, 1 y
    logic signed [WorkW_l-1:0] r_w [NumW];
    logic [3:0]   r_i, r_j;      // pass and element counters
    logic [3:0]   r_rem;         // interpolation passes
    logic [15:0]  r_scale;       // n!/(n-order)!, at most 5040
    logic signed [47:0] r_vx, r_vy;
    logic         r_zero;        // order above curve order
    bte_pkg::t_out_item r_out;
    logic         r_out_valid;

    // divider
    bte_pkg::t_div_req w_div_req;
    bte_pkg::t_div_rsp w_div_rsp;
    bte_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div_req),
        .o_rsp(w_div_rsp));
    assign w_div_req.start    = (r_state == ST_WDATA) && r_found;
    assign w_div_req.dividend = {(r_query - r_acc_t[31:0]), 16'd0};
    assign w_div_req.divisor  = r_seg_dur;

    // ---------------- shared multiply-add unit ----------------
    // one de casteljau term per cycle: (65536-u)*a + u*b + 32768, floor >> 16
    logic signed [WorkW_l-1:0] w_a, w_b;
    logic signed [17:0]        w_um, w_uu;
    logic signed [WorkW_l+18:0] w_mac;
    logic signed [WorkW_l-1:0] w_lerp;
    assign w_a  = r_w[r_j[$clog2(NumW)-1:0]];
    assign w_b  = r_w[r_j[$clog2(NumW)-1:0] + 1'b1];
    assign w_um = 18'sd65536 - $signed({1'b0, r_u});
    assign w_uu = $signed({1'b0, r_u});
    assign w_mac = w_um * w_a + w_uu * w_b + 83'sd32768;
    assign w_lerp = WorkW_l'(w_mac >>> 16);

    // scale product and saturation
    logic signed [80:0] w_prod;
    logic signed [47:0] w_sat;
    assign w_prod = r_w[0] * $signed({1'b0, r_scale});
    always_comb begin
        if (w_prod > 81'sd140737488355327) begin
            w_sat = 48'sh7FFFFFFFFFFF;
        end else if (w_prod < -81'sd140737488355328) begin
            w_sat = 48'sh800000000000;
        end else begin
            w_sat = w_prod[47:0];
        end
    end

    logic [32:0] w_end;
    assign w_end = r_acc_t + {1'b0, w_dur};

    // ---------------- result valid ----------------
    // set when a result is registered, cleared when it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && (!r_out_valid || out_ch.ready)) begin
            r_out_valid <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && w_in.op == bte_pkg::OP_EVALUATE) begin
                        r_query     <= w_in.query_time;
                        r_ord       <= w_in.deriv_order;
                        r_acc_t     <= '0;
                        r_seg       <= '0;
                        r_seg_raddr <= '0;
                        r_cnt_lim   <= ({3'd0, r_seg_count} > MaxSegments)
                                       ? 7'(MaxSegments) : {3'd0, r_seg_count};
                        r_found     <= 1'b0;
                        r_u         <= '0;
                        r_axis      <= 1'b0;
                        r_state     <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    // read address was set; data arrives next cycle
                    r_state <= ST_WDATA;
                end
                ST_WDATA: begin
                    if (r_found) begin
                        r_state <= ST_DIV;
                    end else if (r_seg >= r_cnt_lim || r_cnt_lim == 7'd0) begin
                        // past the end: segment 0 at u = 0
                        r_seg   <= '0;
                        r_i     <= '0;
                        r_pt_raddr <= '0;
                        r_state <= ST_LOAD;
                    end else if ({1'b0, r_query} >= w_end) begin
                        r_acc_t <= w_end;
                        r_seg   <= r_seg + 7'd1;
                        r_seg_raddr <= SegAw'(r_seg + 7'd1);
                        if (r_seg + 7'd1 >= r_cnt_lim) begin
                            r_seg <= r_cnt_lim;
                        end
                        r_state <= ST_WALK;
                    end else begin
                        r_found   <= 1'b1;
                        r_seg_dur <= w_dur;
                        // stay in this state so the divider is started before the divide state
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_u        <= w_div_rsp.quotient;
                        r_i        <= '0;
                        r_pt_raddr <= PtAw'(r_seg * CurveOrder);
                        r_state    <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // i counts issued reads; data lags the registered read, so it is written at i-1
                    if (r_i != 4'd0) begin
                        r_w[r_i[$clog2(NumW)-1:0] - 1'b1] <=
                            WorkW_l'($signed(r_axis ? w_py : w_px));
                    end
                    if (r_i == 4'(NumW)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_scale <= 16'd1;
                        r_zero  <= ({1'b0, r_ord} > 4'(CurveOrder));
                        r_rem   <= 4'(CurveOrder) - {1'b0, r_ord};
                        r_state <= ST_DIFF;
                    end else begin
                        r_i        <= r_i + 4'd1;
                        r_pt_raddr <= r_pt_raddr + PtAw'(1);
                    end
                end
                ST_DIFF: begin
                    // r_i is pass count, r_j element
                    if (r_zero || {1'b0, r_i} >= {2'b0, r_ord}) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_INTERP;
                    end else if (r_j + r_i >= 4'(CurveOrder)) begin
                        r_scale <= r_scale * 16'(CurveOrder - r_i);
                        r_i     <= r_i + 4'd1;
                        r_j     <= '0;
                    end else begin
                        r_w[r_j[$clog2(NumW)-1:0]] <= w_b - w_a;
                        r_j <= r_j + 4'd1;
                    end
                end
                ST_INTERP: begin
                    if (r_zero || r_i >= r_rem) begin
                        r_state <= ST_SCALE;
                    end else if (r_j + r_i >= r_rem) begin
                        r_i <= r_i + 4'd1;
                        r_j <= '0;
                    end else begin
                        r_w[r_j[$clog2(NumW)-1:0]] <= w_lerp;
                        r_j <= r_j + 4'd1;
                    end
                end
                ST_SCALE: begin
                    if (r_axis) begin
                        r_vy <= r_zero ? '0 : w_sat;
                    end else begin
                        r_vx <= r_zero ? '0 : w_sat;
                    end
                    r_state <= ST_AXIS;
                end
                ST_AXIS: begin
                    if (r_axis) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_axis     <= 1'b1;
                        r_i        <= '0;
                        r_pt_raddr <= PtAw'(r_seg * CurveOrder);
                        r_state    <= ST_LOAD;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || out_ch.ready) begin
                        r_out.value_x       <= r_vx;
                        r_out.value_y       <= r_vy;
                        r_out.segment_found <= r_seg[2:0];
                        r_out.beyond_end    <= !r_found;
                        r_state             <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid   = r_out_valid;
    assign out_ch.payload = r_out;

    // ---------------- assertions ----------------
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIV)) else $error("stray divide done");
    a_u_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !r_u[16]) else $error("local time overflow");
endmodule
